FILE: hw/rtl/two_pool_memory_admission_unit_macros.svh
// assertion macros for the two-pool memory admission unit
`ifndef TWO_POOL_MEMORY_ADMISSION_UNIT_MACROS_SVH
`define TWO_POOL_MEMORY_ADMISSION_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define TPMA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpma assertion failed");

// next-cycle implication, held off during reset
`define TPMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpma assertion failed");

`endif

FILE: hw/rtl/tpma_pkg.sv
// shared constants and types for the two-pool memory admission unit
package tpma_pkg;

  localparam int BCW          = 40;
  localparam int QUOTA_W      = 7;
  localparam int PERCENT_FULL = 100;
  localparam int REM_W        = $clog2(PERCENT_FULL);
  localparam int PROD_W       = BCW + QUOTA_W;
  localparam int CFG_IDX_W    = 3;

  // divide by hundred in two slices of the quota product
  localparam int LO_W         = 24;
  localparam int HI_W         = PROD_W - LO_W;
  localparam int HI_SHIFT     = HI_W + REM_W;
  localparam int LO_IN_W      = REM_W + LO_W;
  localparam int LO_SHIFT     = LO_IN_W + REM_W;
  localparam logic [HI_W:0]    RECIP_HI =
    (HI_W + 1)'((64'd1 << HI_SHIFT) / PERCENT_FULL + 1);
  localparam logic [LO_IN_W:0] RECIP_LO =
    (LO_IN_W + 1)'((64'd1 << LO_SHIFT) / PERCENT_FULL + 1);

  localparam int IN_TDATA_W   = ((2 * BCW + 1 + 7) / 8) * 8;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = ((2 * BCW + 1 + 7) / 8) * 8;

  typedef logic [BCW-1:0]       bytes_t;
  typedef logic signed [BCW:0]  delta_t;
  typedef logic [QUOTA_W-1:0]   quota_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_TOTAL    = 3'd0;
  localparam cfg_idx_t REG_QUOTA    = 3'd1;
  localparam cfg_idx_t REG_EXEC_MIN = 3'd2;
  localparam cfg_idx_t REG_EXEC_MAX = 3'd3;
  localparam cfg_idx_t REG_STOR_MIN = 3'd4;
  localparam cfg_idx_t REG_STOR_MAX = 3'd5;

  localparam logic FUNC_ALLOC  = 1'b0;
  localparam logic FUNC_ADJUST = 1'b1;
  localparam logic POOL_EXEC   = 1'b0;
  localparam logic POOL_STOR   = 1'b1;

  localparam quota_t QUOTA_RESET = QUOTA_W'(50);
  localparam quota_t QUOTA_FULL  = QUOTA_W'(PERCENT_FULL);
  localparam bytes_t MIN_RESET   = BCW'(1);
  localparam bytes_t MAX_RESET   = {BCW{1'b1}};

endpackage

FILE: hw/rtl/two_pool_memory_admission_unit.sv
// top level: two-pool byte admission with allocate and adjust beats
// an accepted input beat passes the input stage registers, then the result register once the output is free
// throughput: one beat per cycle when not stalled; the result register frees as the next beat is taken
// a write to total_memory or exec_quota_percent holds in_tready low
// while the storage limit is recomputed by a staged reciprocal divide by hundred
// rst_n (synchronous, active low) clears both used counters and the storage limit and resets the config
module two_pool_memory_admission_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tpma_pkg::IN_TDATA_W-1:0]      in_tdata,  // request_bytes, adjust_delta
  input  logic [tpma_pkg::IN_TUSER_W-1:0]      in_tuser,  // func, pool_select
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [tpma_pkg::OUT_TDATA_W-1:0]     out_tdata, // granted, exec_used_now, storage_used_now
  input  logic                                 cfg_we,
  input  tpma_pkg::cfg_idx_t                   cfg_index,
  input  tpma_pkg::bytes_t                     cfg_wdata
);
  import tpma_pkg::*;

  // configuration
  bytes_t total_r, emin_r, emax_r, smin_r, smax_r;
  quota_t quota_r;

  // input stage
  logic   in_valid_r;
  logic   in_func_r, in_pool_r;
  bytes_t in_req_r;
  delta_t in_delta_r;

  // pool state and result
  bytes_t exec_used_r, stor_used_r;
  bytes_t exec_used_nxt, stor_used_nxt;
  logic   out_valid_r, out_granted_r;
  logic   granted_nxt;

  logic   calc_busy, calc_start;
  bytes_t stor_limit;
  logic   advance;

  bytes_t                   sel_cur, adj_res;
  logic signed [BCW+1:0]    adj_sum;
  logic [BCW:0]             exec_plus, stor_plus;
  logic [BCW+1:0]           all_sum;
  logic                     exec_ok, stor_ok, all_ok, alloc_ok;

  assign calc_start = cfg_we && ((cfg_index == REG_TOTAL) || (cfg_index == REG_QUOTA));

  tpma_limit_calc u_limit (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (calc_start),
    .total         (total_r),
    .quota         (quota_r),
    .busy          (calc_busy),
    .storage_limit (stor_limit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      quota_r <= QUOTA_RESET;
      emin_r  <= MIN_RESET;
      emax_r  <= MAX_RESET;
      smin_r  <= MIN_RESET;
      smax_r  <= MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOTAL:    total_r <= cfg_wdata;
        REG_QUOTA:    quota_r <= cfg_wdata[QUOTA_W-1:0];
        REG_EXEC_MIN: emin_r  <= cfg_wdata;
        REG_EXEC_MAX: emax_r  <= cfg_wdata;
        REG_STOR_MIN: smin_r  <= cfg_wdata;
        REG_STOR_MAX: smax_r  <= cfg_wdata;
        default: begin
          total_r <= total_r;
        end
      endcase
    end
  end

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !calc_busy && (!in_valid_r || advance);

  // allocate checks
  assign exec_plus = {1'b0, exec_used_r} + {1'b0, in_req_r};
  assign stor_plus = {1'b0, stor_used_r} + {1'b0, in_req_r};
  assign all_sum   = {2'b00, exec_used_r} + {2'b00, stor_used_r} + {2'b00, in_req_r};

  assign exec_ok = (in_req_r <= emax_r) && (in_req_r >= emin_r) && (in_req_r <= total_r)
                   && (exec_plus <= {1'b0, total_r});
  assign stor_ok = (in_req_r <= smax_r) && (in_req_r >= smin_r) && (in_req_r <= stor_limit)
                   && (stor_plus <= {1'b0, stor_limit});
  assign all_ok  = all_sum <= {2'b00, total_r};
  assign alloc_ok = ((in_pool_r == POOL_STOR) ? stor_ok : exec_ok) && all_ok;

  // adjust with saturation at zero and at the total
  assign sel_cur = (in_pool_r == POOL_STOR) ? stor_used_r : exec_used_r;
  assign adj_sum = $signed({2'b00, sel_cur}) + $signed({in_delta_r[BCW], in_delta_r});

  always_comb begin
    if (adj_sum[BCW+1]) begin
      adj_res = '0;
    end else if (adj_sum[BCW:0] > {1'b0, total_r}) begin
      adj_res = total_r;
    end else begin
      adj_res = adj_sum[BCW-1:0];
    end
  end

  always_comb begin
    exec_used_nxt = exec_used_r;
    stor_used_nxt = stor_used_r;
    granted_nxt   = 1'b1;
    unique case (in_func_r)
      FUNC_ALLOC: begin
        granted_nxt = alloc_ok;
        if (alloc_ok) begin
          if (in_pool_r == POOL_STOR) begin
            stor_used_nxt = stor_plus[BCW-1:0];
          end else begin
            exec_used_nxt = exec_plus[BCW-1:0];
          end
        end
      end
      FUNC_ADJUST: begin
        if (in_pool_r == POOL_STOR) begin
          stor_used_nxt = adj_res;
        end else begin
          exec_used_nxt = adj_res;
        end
      end
      default: begin
        granted_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      exec_used_r <= '0;
      stor_used_r <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        exec_used_r <= exec_used_nxt;
        stor_used_r <= stor_used_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // beat payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_func_r  <= in_tuser[0];
      in_pool_r  <= in_tuser[1];
      in_req_r   <= in_tdata[BCW-1:0];
      in_delta_r <= in_tdata[2*BCW:BCW];
    end
    if (advance) begin
      out_granted_r <= granted_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2 * BCW - 1){1'b0}}, stor_used_r, exec_used_r,
                       out_granted_r};

  logic unused_in_pad;
  assign unused_in_pad = ^in_tdata[IN_TDATA_W-1:2*BCW+1];

endmodule

FILE: hw/rtl/tpma_limit_calc.sv
// storage pool limit: total minus floor(total * quota / 100), quota clamped to 100, by a staged reciprocal divide
module tpma_limit_calc (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  tpma_pkg::bytes_t total,
  input  tpma_pkg::quota_t quota,
  output logic             busy,
  output tpma_pkg::bytes_t storage_limit
);
  import tpma_pkg::*;

  typedef enum logic [2:0] {
    LC_IDLE, LC_MUL, LC_HI_QUOT, LC_HI_REM, LC_LO_QUOT, LC_DONE
  } lc_state_t;

  lc_state_t                   state_r;
  logic [PROD_W-1:0]           prod_r;
  logic [HI_W-1:0]             hi_quot_r;
  logic [LO_IN_W-1:0]          lo_in_r;
  logic [LO_W-1:0]             lo_quot_r;
  bytes_t                      limit_r;

  quota_t                      quota_clamped;
  logic [2*HI_W:0]             hi_mul;
  logic [HI_W-1:0]             hi_back;
  logic [HI_W-1:0]             hi_diff;
  logic [LO_SHIFT+LO_W-1:0]    lo_mul;
  bytes_t                      share;

  assign quota_clamped = (quota > QUOTA_FULL) ? QUOTA_FULL : quota;

  // upper slice quotient, then its remainder carried into the lower slice
  assign hi_mul  = (2 * HI_W + 1)'(prod_r[PROD_W-1:LO_W]) * (2 * HI_W + 1)'(RECIP_HI);
  assign hi_back = hi_quot_r * HI_W'(PERCENT_FULL);
  assign hi_diff = prod_r[PROD_W-1:LO_W] - hi_back;
  assign lo_mul  = (LO_SHIFT + LO_W)'(lo_in_r) * (LO_SHIFT + LO_W)'(RECIP_LO);
  assign share   = bytes_t'({hi_quot_r, {LO_W{1'b0}}}) + bytes_t'(lo_quot_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LC_IDLE;
      limit_r <= '0;
    end else if (start) begin
      state_r <= LC_MUL;
    end else begin
      unique case (state_r)
        LC_IDLE: begin
          state_r <= LC_IDLE;
        end
        LC_MUL: begin
          prod_r  <= PROD_W'(total) * PROD_W'(quota_clamped);
          state_r <= LC_HI_QUOT;
        end
        LC_HI_QUOT: begin
          hi_quot_r <= HI_W'(hi_mul[2*HI_W:HI_SHIFT]);
          state_r   <= LC_HI_REM;
        end
        LC_HI_REM: begin
          lo_in_r <= {hi_diff[REM_W-1:0], prod_r[LO_W-1:0]};
          state_r <= LC_LO_QUOT;
        end
        LC_LO_QUOT: begin
          lo_quot_r <= lo_mul[LO_SHIFT+LO_W-1:LO_SHIFT];
          state_r   <= LC_DONE;
        end
        LC_DONE: begin
          limit_r <= total - share;
          state_r <= LC_IDLE;
        end
        default: begin
          state_r <= LC_IDLE;
        end
      endcase
    end
  end

  assign busy          = start || (state_r != LC_IDLE);
  assign storage_limit = limit_r;

endmodule

FILE: hw/rtl/tpma_checker.sv
// port-level checks for the two-pool memory admission unit, bound to the top level
`include "two_pool_memory_admission_unit_macros.svh"

module tpma_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [tpma_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [tpma_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tpma_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             cfg_we,
  input tpma_pkg::cfg_idx_t               cfg_index,
  input tpma_pkg::bytes_t                 cfg_wdata
);
  import tpma_pkg::*;

  logic   seen_r;
  bytes_t last_exec_r, last_stor_r;
  bytes_t beat_exec, beat_stor;
  logic   exec_moved, stor_moved;

  assign beat_exec  = out_tdata[BCW:1];
  assign beat_stor  = out_tdata[2*BCW:BCW+1];
  assign exec_moved = seen_r && (beat_exec != last_exec_r);
  assign stor_moved = seen_r && (beat_stor != last_stor_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      seen_r      <= 1'b1;
      last_exec_r <= beat_exec;
      last_stor_r <= beat_stor;
    end
  end

  `TPMA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata))
  `TPMA_ASSERT_NOW(a_denied_no_change, clk, rst_n, out_tvalid && !out_tdata[0],
                   !exec_moved && !stor_moved)
  `TPMA_ASSERT_NOW(a_one_pool_moves, clk, rst_n, out_tvalid, !(exec_moved && stor_moved))
  `TPMA_ASSERT_NEXT(a_limit_recompute_stalls, clk, rst_n,
                    cfg_we && (cfg_index == REG_TOTAL || cfg_index == REG_QUOTA), !in_tready)

  logic unused_ports;
  assign unused_ports = in_tvalid ^ (^in_tdata) ^ (^in_tuser) ^ (^cfg_wdata);

endmodule

bind two_pool_memory_admission_unit tpma_checker u_tpma_checker (.*);
